### rtl/cges_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the central gravity Euler step core.
// No dependencies.
package cges_pkg;

    localparam int IO_BITS    = 64;
    localparam int GP_BITS    = 52;
    localparam int WIDE_BITS  = 128;
    localparam int HALF_BITS  = 32;
    localparam int SQRT_STEPS = 64;
    localparam int SQ_STEPS   = 12;
    localparam int DV_STEPS   = 2;

    typedef logic [7:0] t_cnt;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_POS  = 2'd1;
    localparam logic [1:0] MODE_VEL  = 2'd2;

    localparam logic [1:0] FAULT_OK   = 2'd0;
    localparam logic [1:0] FAULT_ZERO = 2'd1;
    localparam logic [1:0] FAULT_SAT  = 2'd2;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_GRAV   = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_POS,
        OP_LOAD_VEL,
        OP_CLEAR,
        OP_MOVE,
        OP_SQRT,
        OP_MARK_ZERO,
        OP_DIV_Q1,
        OP_DIV_A,
        OP_DIV_U,
        OP_DIV_STEP,
        OP_ACC_MAX,
        OP_ACC_SET,
        OP_VUPD,
        OP_WRITE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        logic [1:0] part;
        logic       mul_en;
        logic       acc_en;
        logic       mul_sq;
    } t_dp_cmd;

    typedef struct packed {
        logic root_zero;
        logic q1_big;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/cges_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the Euler step: decodes input words and steps the datapath.
// Depends on cges_pkg.
module cges_ctrl #(
    parameter int WORD_BITS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic                 i_orbit_enable,
    input  cges_pkg::t_dp_status i_status,
    output cges_pkg::t_dp_cmd    o_cmd
);

    localparam cges_pkg::t_cnt L_Q1   = cges_pkg::t_cnt'(cges_pkg::GP_BITS + 2 * FRAC_BITS);
    localparam cges_pkg::t_cnt L_A    = cges_pkg::t_cnt'(cges_pkg::WIDE_BITS);
    localparam cges_pkg::t_cnt L_U    = cges_pkg::t_cnt'(WORD_BITS + FRAC_BITS);
    localparam cges_pkg::t_cnt L_SQ   = cges_pkg::t_cnt'(cges_pkg::SQ_STEPS);
    localparam cges_pkg::t_cnt L_RT   = cges_pkg::t_cnt'(cges_pkg::SQRT_STEPS - 1);
    localparam cges_pkg::t_cnt L_DV   = cges_pkg::t_cnt'(cges_pkg::DV_STEPS);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_MOVE = 13'b0000000000010,
        S_SQ   = 13'b0000000000100,
        S_SQRT = 13'b0000000001000,
        S_ROOT = 13'b0000000010000,
        S_DQ1  = 13'b0000000100000,
        S_QCHK = 13'b0000001000000,
        S_DA   = 13'b0000010000000,
        S_ACC  = 13'b0000100000000,
        S_DU   = 13'b0001000000000,
        S_MUL  = 13'b0010000000000,
        S_VUPD = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state          r_state, n_state;
    cges_pkg::t_cnt  r_cnt, n_cnt;
    logic [1:0]      r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.op = cges_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DONE;
                    case (i_mode)
                        cges_pkg::MODE_POS: o_cmd.op = cges_pkg::OP_LOAD_POS;
                        cges_pkg::MODE_VEL: o_cmd.op = cges_pkg::OP_LOAD_VEL;
                        cges_pkg::MODE_TICK: begin
                            o_cmd.op = cges_pkg::OP_CLEAR;
                            if (i_orbit_enable) begin
                                n_state = S_MOVE;
                            end
                        end
                        default: o_cmd.op = cges_pkg::OP_CLEAR;
                    endcase
                end
            end
            S_MOVE: begin
                o_cmd.op = cges_pkg::OP_MOVE;
                n_cnt    = '0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.mul_sq = 1'b1;
                o_cmd.mul_en = (r_cnt < L_SQ);
                o_cmd.acc_en = (r_cnt != '0);
                o_cmd.axis   = r_cnt[3:2];
                o_cmd.part   = r_cnt[1:0];
                if (r_cnt == L_SQ) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.op = cges_pkg::OP_SQRT;
                if (r_cnt == L_RT) begin
                    n_cnt   = '0;
                    n_state = S_ROOT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROOT: begin
                if (i_status.root_zero) begin
                    o_cmd.op = cges_pkg::OP_MARK_ZERO;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_DQ1;
                end
            end
            S_DQ1: begin
                o_cmd.op = (r_cnt == '0) ? cges_pkg::OP_DIV_Q1 : cges_pkg::OP_DIV_STEP;
                if (r_cnt == L_Q1) begin
                    n_cnt   = '0;
                    n_state = S_QCHK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_QCHK: begin
                n_axis = '0;
                if (i_status.q1_big) begin
                    o_cmd.op = cges_pkg::OP_ACC_MAX;
                    n_state  = S_DU;
                end else begin
                    n_state = S_DA;
                end
            end
            S_DA: begin
                o_cmd.op = (r_cnt == '0) ? cges_pkg::OP_DIV_A : cges_pkg::OP_DIV_STEP;
                if (r_cnt == L_A) begin
                    n_cnt   = '0;
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ACC: begin
                o_cmd.op = cges_pkg::OP_ACC_SET;
                n_state  = S_DU;
            end
            S_DU: begin
                o_cmd.axis = r_axis;
                o_cmd.op   = (r_cnt == '0) ? cges_pkg::OP_DIV_U : cges_pkg::OP_DIV_STEP;
                if (r_cnt == L_U) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.axis   = r_axis;
                o_cmd.mul_en = (r_cnt < L_DV);
                o_cmd.acc_en = (r_cnt != '0);
                o_cmd.part   = {1'b0, r_cnt[0]};
                if (r_cnt == L_DV) begin
                    n_cnt   = '0;
                    n_state = S_VUPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_VUPD: begin
                o_cmd.op   = cges_pkg::OP_VUPD;
                o_cmd.axis = r_axis;
                if (r_axis == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_DU;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = cges_pkg::OP_WRITE;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/cges_datapath.sv
`timescale 1ns / 1ps
// Datapath: body state, shared multiplier, square root and divider steps,
// result register. Depends on cges_pkg.
module cges_datapath #(
    parameter int WORD_BITS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cges_pkg::t_dp_cmd                 i_cmd,
    output cges_pkg::t_dp_status              o_status,
    input  logic [cges_pkg::GP_BITS-1:0]      i_grav_param,
    input  logic signed [cges_pkg::IO_BITS-1:0] i_vec_x,
    input  logic signed [cges_pkg::IO_BITS-1:0] i_vec_y,
    input  logic signed [cges_pkg::IO_BITS-1:0] i_vec_z,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [6*cges_pkg::IO_BITS-1:0]    o_out_data,
    output logic [1:0]                        o_out_fault
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int WIDE = cges_pkg::WIDE_BITS;
    localparam int HALF = cges_pkg::HALF_BITS;
    localparam int IO   = cges_pkg::IO_BITS;

    localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [IO-1:0] WMAX64 = IO'(WMAX);
    localparam logic signed [IO-1:0] WMIN64 = IO'(WMIN);

    logic signed [W-1:0]   r_pos [3];
    logic signed [W-1:0]   r_vel [3];
    logic                  r_sat;
    logic                  r_zero;
    logic [WIDE-1:0]       r_sum;
    logic [66:0]           r_rem;
    logic [63:0]           r_root;
    logic [WIDE-1:0]       r_num;
    logic [WIDE-1:0]       r_quo;
    logic [63:0]           r_drem;
    logic [W-2:0]          r_accel;
    logic [64:0]           r_prod;
    logic [1:0]            r_psh;
    logic                  r_out_valid;
    logic [6*IO-1:0]       r_out_data;
    logic [1:0]            r_out_fault;

    logic signed [W-1:0]   sel_pos, sel_vel;
    logic                  p_neg;
    logic [W-1:0]          mag;
    logic [63:0]           m64, acc64;
    logic [32:0]           mul_a;
    logic [31:0]           mul_b;
    logic [1:0]            mul_sh;
    logic [64:0]           mul_p;
    logic [WIDE-1:0]       acc_add;

    logic signed [W:0]     mv_sum [3];
    logic [2:0]            mv_ovf;
    logic signed [W-1:0]   mv_res [3];

    logic signed [IO-1:0]  ld_in  [3];
    logic [2:0]            ld_ovf;
    logic signed [W-1:0]   ld_res [3];

    logic [W-2:0]          dv;
    logic signed [W:0]     vu_sum;
    logic                  vu_ovf;
    logic signed [W-1:0]   vu_res;

    logic [66:0]           sq_rem2, sq_trial;
    logic                  sq_ge;
    logic [64:0]           dv_tmp;
    logic                  dv_ge;

    always_comb begin
        case (i_cmd.axis)
            2'd0: begin
                sel_pos = r_pos[0];
                sel_vel = r_vel[0];
            end
            2'd1: begin
                sel_pos = r_pos[1];
                sel_vel = r_vel[1];
            end
            default: begin
                sel_pos = r_pos[2];
                sel_vel = r_vel[2];
            end
        endcase
    end

    assign p_neg = sel_pos[W-1];
    assign mag   = p_neg ? W'(-sel_pos) : W'(sel_pos);
    assign m64   = 64'(mag);
    assign acc64 = 64'(r_accel);

    always_comb begin
        if (i_cmd.mul_sq) begin
            mul_a  = {1'b0, i_cmd.part[1] ? m64[2*HALF-1:HALF] : m64[HALF-1:0]};
            mul_b  = i_cmd.part[0] ? m64[2*HALF-1:HALF] : m64[HALF-1:0];
            mul_sh = 2'(i_cmd.part[1]) + 2'(i_cmd.part[0]);
        end else begin
            mul_a  = 33'(r_quo[F:0]);
            mul_b  = i_cmd.part[0] ? acc64[2*HALF-1:HALF] : acc64[HALF-1:0];
            mul_sh = {1'b0, i_cmd.part[0]};
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_add = r_sum + ({63'b0, r_prod} << {r_psh, 5'b0});

    assign ld_in[0] = i_vec_x;
    assign ld_in[1] = i_vec_y;
    assign ld_in[2] = i_vec_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mv_sum[i] = {r_pos[i][W-1], r_pos[i]} + {r_vel[i][W-1], r_vel[i]};
            mv_ovf[i] = mv_sum[i][W] ^ mv_sum[i][W-1];
            mv_res[i] = mv_ovf[i] ? (mv_sum[i][W] ? WMIN : WMAX) : mv_sum[i][W-1:0];
            ld_ovf[i] = (ld_in[i] > WMAX64) || (ld_in[i] < WMIN64);
            if (ld_in[i] > WMAX64) begin
                ld_res[i] = WMAX;
            end else if (ld_in[i] < WMIN64) begin
                ld_res[i] = WMIN;
            end else begin
                ld_res[i] = ld_in[i][W-1:0];
            end
        end
    end

    assign dv     = r_sum[F +: W-1];
    assign vu_sum = p_neg ? ({sel_vel[W-1], sel_vel} + {2'b00, dv})
                          : ({sel_vel[W-1], sel_vel} - {2'b00, dv});
    assign vu_ovf = vu_sum[W] ^ vu_sum[W-1];
    assign vu_res = vu_ovf ? (vu_sum[W] ? WMIN : WMAX) : vu_sum[W-1:0];

    assign sq_rem2  = {r_rem[64:0], r_sum[WIDE-1:WIDE-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);

    assign dv_tmp = {r_drem, r_num[WIDE-1]};
    assign dv_ge  = (dv_tmp >= {1'b0, r_root});

    // state and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                cges_pkg::OP_LOAD_POS: begin
                    for (int i = 0; i < 3; i++) r_pos[i] <= ld_res[i];
                end
                cges_pkg::OP_LOAD_VEL: begin
                    for (int i = 0; i < 3; i++) r_vel[i] <= ld_res[i];
                end
                cges_pkg::OP_MOVE: begin
                    for (int i = 0; i < 3; i++) r_pos[i] <= mv_res[i];
                end
                cges_pkg::OP_VUPD: begin
                    case (i_cmd.axis)
                        2'd0:    r_vel[0] <= vu_res;
                        2'd1:    r_vel[1] <= vu_res;
                        default: r_vel[2] <= vu_res;
                    endcase
                end
                default: ;
            endcase
            if (i_cmd.op == cges_pkg::OP_WRITE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
            r_psh  <= mul_sh;
        end
        unique case (i_cmd.op)
            cges_pkg::OP_LOAD_POS, cges_pkg::OP_LOAD_VEL: begin
                r_sat  <= |ld_ovf;
                r_zero <= 1'b0;
            end
            cges_pkg::OP_CLEAR: begin
                r_sat  <= 1'b0;
                r_zero <= 1'b0;
                r_sum  <= '0;
            end
            cges_pkg::OP_MOVE: begin
                r_sat  <= r_sat | (|mv_ovf);
                r_rem  <= '0;
                r_root <= '0;
            end
            cges_pkg::OP_SQRT: begin
                r_rem  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
                r_root <= {r_root[62:0], sq_ge};
                r_sum  <= r_sum << 2;
            end
            cges_pkg::OP_MARK_ZERO: r_zero <= 1'b1;
            cges_pkg::OP_DIV_Q1: begin
                r_num  <= {i_grav_param, {(WIDE-cges_pkg::GP_BITS){1'b0}}};
                r_quo  <= '0;
                r_drem <= '0;
            end
            cges_pkg::OP_DIV_A: begin
                r_num  <= r_quo << F;
                r_quo  <= '0;
                r_drem <= '0;
            end
            cges_pkg::OP_DIV_U: begin
                r_num  <= {mag, {(WIDE-W){1'b0}}};
                r_quo  <= '0;
                r_drem <= '0;
                r_sum  <= '0;
            end
            cges_pkg::OP_DIV_STEP: begin
                r_drem <= dv_ge ? 64'(dv_tmp - {1'b0, r_root}) : dv_tmp[63:0];
                r_quo  <= {r_quo[WIDE-2:0], dv_ge};
                r_num  <= r_num << 1;
            end
            cges_pkg::OP_ACC_MAX: begin
                r_accel <= '1;
                r_sat   <= 1'b1;
            end
            cges_pkg::OP_ACC_SET: begin
                if (|r_quo[WIDE-1:W-1]) begin
                    r_accel <= '1;
                    r_sat   <= 1'b1;
                end else begin
                    r_accel <= r_quo[W-2:0];
                end
            end
            cges_pkg::OP_VUPD: r_sat <= r_sat | vu_ovf;
            cges_pkg::OP_WRITE: begin
                r_out_data <= {IO'(r_vel[2]), IO'(r_vel[1]), IO'(r_vel[0]),
                               IO'(r_pos[2]), IO'(r_pos[1]), IO'(r_pos[0])};
                r_out_fault <= r_zero ? cges_pkg::FAULT_ZERO :
                               (r_sat ? cges_pkg::FAULT_SAT : cges_pkg::FAULT_OK);
            end
            default: begin
                if (i_cmd.acc_en) begin
                    r_sum <= acc_add;
                end
            end
        endcase
    end

    assign o_status.root_zero = (r_root == '0);
    assign o_status.q1_big    = |r_quo[WIDE-1 -: F];
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_fault = r_out_fault;

endmodule

### rtl/central_gravity_euler_step_core.sv
`timescale 1ns / 1ps
// One body around a fixed central mass, one semi-implicit Euler tick per word: position
// moves by velocity, then velocity is pulled toward the center by grav_param / |p|^2.
// A tick with orbit_enable set skips the second division when the acceleration
// saturates early; a tick that lands on the center stops after the root. The
// one-bit-per-cycle divider (five divisions) and the 64-step square root do the work.
// One word is worked on at a time; the next is taken while the previous result waits
// in the output register.
// Depends on cges_pkg, cges_ctrl, cges_datapath.
module central_gravity_euler_step_core #(
    parameter int WORD_BITS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [51:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [191:0]  s_axis_tdata,   // vec_x, vec_y, vec_z
    input  logic [1:0]    s_axis_tuser,   // mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [383:0]  m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [1:0]    m_axis_tuser    // fault
);

    logic                             r_orbit_enable;
    logic [cges_pkg::GP_BITS-1:0]     r_grav_param;
    cges_pkg::t_dp_cmd                cmd;
    cges_pkg::t_dp_status             status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbit_enable <= 1'b0;
            r_grav_param   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cges_pkg::CFG_ENABLE) begin
                r_orbit_enable <= i_cfg_data[0];
            end else if (i_cfg_idx == cges_pkg::CFG_GRAV) begin
                r_grav_param <= i_cfg_data;
            end
        end
    end

    cges_ctrl #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_mode         (s_axis_tuser),
        .i_orbit_enable (r_orbit_enable),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    cges_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_grav_param (r_grav_param),
        .i_vec_x      (s_axis_tdata[63:0]),
        .i_vec_y      (s_axis_tdata[127:64]),
        .i_vec_z      (s_axis_tdata[191:128]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_fault  (m_axis_tuser)
    );

endmodule

### rtl/cges_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Euler step core, bound to the top level.
// Depends on central_gravity_euler_step_core.
module cges_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic [1:0]    s_axis_tuser,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [383:0]  m_axis_tdata,
    input logic [1:0]    m_axis_tuser
);

    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("fault code out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == 2'd3) |=>
            !s_axis_tready)
        else $error("unused mode not consumed as one word");

endmodule

bind central_gravity_euler_step_core cges_checker u_cges_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for central_gravity_euler_step_core: a bit-exact orbit predictor in a
// scoreboard checks every output word against loads and ticks under several settings.
// Depends on cges_pkg and the core RTL.
module testbench;

    localparam int FB = 16;
    localparam logic [63:0] WMAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] WMIN = 64'h8000_0000_0000_0000;
    localparam logic [51:0] GP_MAX = {52{1'b1}};
    localparam longint CYCLE_LIMIT = 5_000_000;

    typedef struct {
        logic [63:0] pos [3];
        logic [63:0] vel [3];
        logic [1:0]  fault;
    } t_body_state;

    class t_orbit_scoreboard;
        logic        enable;
        logic [51:0] gm;
        logic [63:0] pos [3];
        logic [63:0] vel [3];
        t_body_state expected_q[$];
        int mismatches;
        int checked;
        int ticks;
        int zero_faults;
        int sat_faults;

        function new();
            enable = 1'b0;
            gm = '0;
            for (int i = 0; i < 3; i++) begin
                pos[i] = '0;
                vel[i] = '0;
            end
            mismatches = 0;
            checked = 0;
            ticks = 0;
            zero_faults = 0;
            sat_faults = 0;
        endfunction

        function void set_reg(logic idx, logic [51:0] val);
            if (idx == cges_pkg::CFG_ENABLE) enable = val[0];
            else gm = val;
        endfunction

        function logic [63:0] clamp_sum(logic [63:0] a, logic [63:0] b, ref logic sat);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) begin
                sat = 1'b1;
                return s[64] ? WMIN : WMAX;
            end
            return s[63:0];
        endfunction

        function logic [63:0] mag(logic [63:0] v);
            return v[63] ? -v : v;
        endfunction

        function logic [63:0] root(logic [127:0] n);
            logic [63:0] r;
            logic [63:0] t;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if ({64'd0, t} * {64'd0, t} <= n) r = t;
            end
            return r;
        endfunction

        function logic [1:0] advance();
            logic        sat;
            logic [127:0] sum;
            logic [127:0] q;
            logic [127:0] u;
            logic [127:0] prod;
            logic [63:0] root_d;
            logic [63:0] accel;
            logic [63:0] m;
            logic [63:0] dv;
            sat = 1'b0;
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                pos[i] = clamp_sum(pos[i], vel[i], sat);
                m = mag(pos[i]);
                sum += {64'd0, m} * {64'd0, m};
            end
            root_d = root(sum);
            if (root_d == 0) return cges_pkg::FAULT_ZERO;
            q = ({76'd0, gm} << (2 * FB)) / {64'd0, root_d};
            if (q[127:128-FB] != 0) begin
                accel = WMAX;
                sat = 1'b1;
            end else begin
                q = (q << FB) / {64'd0, root_d};
                if (q[127:63] != 0) begin
                    accel = WMAX;
                    sat = 1'b1;
                end else begin
                    accel = q[63:0];
                end
            end
            for (int i = 0; i < 3; i++) begin
                u = ({64'd0, mag(pos[i])} << FB) / {64'd0, root_d};
                prod = {64'd0, u[63:0]} * {64'd0, accel};
                dv = prod[FB+63:FB];
                if (pos[i][63]) dv = -dv;
                vel[i] = clamp_sum(vel[i], -dv, sat);
            end
            return sat ? cges_pkg::FAULT_SAT : cges_pkg::FAULT_OK;
        endfunction

        function void note_input(logic [1:0] mode, logic [191:0] vec);
            t_body_state e;
            e.fault = cges_pkg::FAULT_OK;
            if (mode == cges_pkg::MODE_TICK) begin
                if (enable) begin
                    e.fault = advance();
                    ticks++;
                end
            end else if (mode == cges_pkg::MODE_POS) begin
                for (int i = 0; i < 3; i++) pos[i] = vec[64*i +: 64];
            end else if (mode == cges_pkg::MODE_VEL) begin
                for (int i = 0; i < 3; i++) vel[i] = vec[64*i +: 64];
            end
            if (e.fault == cges_pkg::FAULT_ZERO) zero_faults++;
            if (e.fault == cges_pkg::FAULT_SAT) sat_faults++;
            for (int i = 0; i < 3; i++) begin
                e.pos[i] = pos[i];
                e.vel[i] = vel[i];
            end
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [383:0] data, logic [1:0] fault);
            t_body_state e;
            logic bad;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word %h", data);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            bad = (fault != e.fault);
            for (int i = 0; i < 3; i++) begin
                if (data[64*i +: 64] != e.pos[i]) bad = 1'b1;
                if (data[192 + 64*i +: 64] != e.vel[i]) bad = 1'b1;
            end
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch #%0d fault exp %0d got %0d", checked, e.fault, fault);
                    $display("  exp pos %h %h %h vel %h %h %h", e.pos[0], e.pos[1],
                             e.pos[2], e.vel[0], e.vel[1], e.vel[2]);
                    $display("  got %h", data);
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_idx;
    logic [51:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [383:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    t_orbit_scoreboard sb = new();
    longint cycles = 0;
    int     items = 0;
    logic   no_stall = 1'b0;

    central_gravity_euler_step_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[central_gravity_euler_step_core] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (no_stall || r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || no_stall) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(99) < 75);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // signed value with a magnitude of about nbits bits
    function automatic logic [63:0] rand_scaled(int nbits);
        logic [63:0] v;
        v = rand64() >> (64 - nbits);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic send(logic [1:0] mode, logic [63:0] x, logic [63:0] y, logic [63:0] z);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items++;
    endtask

    task automatic tick();
        send(cges_pkg::MODE_TICK, rand64(), rand64(), rand64());
    endtask

    task automatic set_reg(logic idx, logic [51:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int stop;
        int n;
        int sc;
        stop = items + count;
        while (items < stop) begin
            if ($urandom_range(49) == 0) no_stall = ~no_stall;
            if ($urandom_range(99) < 75) begin
                sc = $urandom_range(62, 18);
                send(cges_pkg::MODE_POS, rand_scaled(sc), rand_scaled(sc), rand_scaled(sc));
                sc = $urandom_range(1) ? sc - $urandom_range(12, 4) : $urandom_range(63, 1);
                send(cges_pkg::MODE_VEL, rand_scaled(sc), rand_scaled(sc), rand_scaled(sc));
                n = $urandom_range(8, 2);
                repeat (n) tick();
            end else begin
                send(2'($urandom_range(3)), rand64(), rand64(), rand64());
            end
        end
        no_stall = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= cges_pkg::CFG_ENABLE;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= cges_pkg::MODE_TICK;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a disabled tick, the unused mode, extreme loads
        send(cges_pkg::MODE_POS, WMAX, WMIN, 64'd0);
        send(cges_pkg::MODE_VEL, WMIN, WMAX, {64{1'b1}});
        tick();
        send(2'd3, WMAX, WMAX, WMAX);

        set_reg(cges_pkg::CFG_ENABLE, 52'd1);
        set_reg(cges_pkg::CFG_GRAV, '0);
        send(cges_pkg::MODE_POS, '0, '0, '0);
        send(cges_pkg::MODE_VEL, '0, '0, '0);
        tick();
        send(cges_pkg::MODE_POS, WMAX, WMIN, 64'd1 << 30);
        send(cges_pkg::MODE_VEL, 64'd5, -64'd5, '0);
        tick();
        send(cges_pkg::MODE_POS, -64'd100, '0, '0);
        send(cges_pkg::MODE_VEL, 64'd100, '0, '0);
        tick();

        set_reg(cges_pkg::CFG_GRAV, GP_MAX);
        send(cges_pkg::MODE_POS, 64'd1, '0, '0);
        send(cges_pkg::MODE_VEL, '0, '0, '0);
        tick();
        send(cges_pkg::MODE_POS, 64'd40 << FB, -(64'd30 << FB), 64'd7 << FB);
        tick();
        send(cges_pkg::MODE_POS, WMIN, WMIN, WMIN);
        send(cges_pkg::MODE_VEL, WMAX, WMAX, WMAX);
        tick();
        tick();

        random_phase(220);
        set_reg(cges_pkg::CFG_GRAV, 52'({$urandom, $urandom} >> 40));
        random_phase(220);
        set_reg(cges_pkg::CFG_ENABLE, '0);
        set_reg(cges_pkg::CFG_GRAV, 52'({$urandom, $urandom}));
        random_phase(100);
        set_reg(cges_pkg::CFG_ENABLE, 52'd1);
        random_phase(220);
        set_reg(cges_pkg::CFG_GRAV, 52'd1);
        random_phase(130);
        set_reg(cges_pkg::CFG_GRAV, GP_MAX);
        random_phase(140);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("%0d words in, %0d checked: %0d enabled ticks, %0d zero-distance, %0d saturated",
                 items, sb.checked, sb.ticks, sb.zero_faults, sb.sat_faults);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[central_gravity_euler_step_core] OK");
        end else begin
            $display("%0d mismatches, %0d words missing", sb.mismatches, sb.expected_q.size());
            $display("[central_gravity_euler_step_core] ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/cges_pkg.sv
rtl/cges_ctrl.sv
rtl/cges_datapath.sv
rtl/central_gravity_euler_step_core.sv
rtl/cges_checker.sv
bench/testbench.sv
